// ===== hdl/mmp_pkg.sv =====
`timescale 1ns / 1ps

package mmp_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int VALUE_BITS_DEF = 31;

  localparam int FIELD_W   = 31;
  localparam int EXP_W     = 63;
  localparam int POS_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [30:0] MODULUS_RESET   = 31'd1000000007;
  localparam logic [3:0]  DIMENSION_RESET = 4'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b1;

  // item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POWER = 1'b1;

  typedef struct packed {
    logic               action;
    logic [POS_W-1:0]   row_index;
    logic [POS_W-1:0]   col_index;
    logic [FIELD_W-1:0] entry_value;
    logic [EXP_W-1:0]   exponent;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [FIELD_W-1:0] out_value;
    logic               last_entry;
  } out_item_t;

endpackage

// ===== hdl/mmp_ram.sv =====
`timescale 1ns / 1ps

module mmp_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                       rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== hdl/modular_matrix_power_unit.sv =====
`timescale 1ns / 1ps

// Modular matrix power. Load items (action 0) store one entry of the base matrix,
// reduced modulo the modulus. A power item (action 1) raises the leading n x n
// block to the exponent by square-and-multiply and then emits the n*n result
// entries in row-major order with last_entry on the final one. Every product
// goes through one bit-serial modular multiplier, one bit per step, and a
// power item costs up to two matrix products per exponent bit. in_ready is
// high only while the block is idle; a finished result may still sit in the
// output register while the next item is accepted.
module modular_matrix_power_unit #(
  parameter int MAX_DIM    = mmp_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = mmp_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mmp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mmp_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [mmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mmp_pkg::*;

  localparam int VB      = VALUE_BITS;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELL_AW = 2 * IDX_W;
  localparam int CELLS   = 1 << CELL_AW;
  localparam int CNT_W   = $clog2(VB + 1);
  localparam logic [3:0] MAXD4 = 4'(MAX_DIM);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_LWR   = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_ILD   = 4'd4;
  localparam logic [3:0] S_CPY   = 4'd5;
  localparam logic [3:0] S_CWR   = 4'd6;
  localparam logic [3:0] S_PSEL  = 4'd7;
  localparam logic [3:0] S_SHIFT = 4'd8;
  localparam logic [3:0] S_MRD   = 4'd9;
  localparam logic [3:0] S_MLD   = 4'd10;
  localparam logic [3:0] S_MMUL  = 4'd11;
  localparam logic [3:0] S_MACC  = 4'd12;
  localparam logic [3:0] S_ERD   = 4'd13;
  localparam logic [3:0] S_EPUT  = 4'd14;

  logic [3:0]          state_r, state_nxt;
  logic [30:0]         modulus_r, modulus_nxt;
  logic [3:0]          dimension_r, dimension_nxt;
  logic [CELLS-1:0]    base_vld_r, base_vld_nxt;
  logic                base_vq_r;
  logic                acc_bank_r, acc_bank_nxt;
  logic                scr_bank_r, scr_bank_nxt;
  logic                sq_mode_r, sq_mode_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [EXP_W-1:0]    p_r, p_nxt;
  logic [IDX_W-1:0]    ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic                ld_ok_r, ld_ok_nxt;
  logic [VB-1:0]       mm_a_r, mm_a_nxt, mm_b_r, mm_b_nxt, mm_r_r, mm_r_nxt;
  logic [CNT_W-1:0]    mm_cnt_r, mm_cnt_nxt;
  logic [VB-1:0]       sum_r, sum_nxt;

  logic [VB-1:0]       m_low, m_eff;
  logic [3:0]          dim_eff;
  logic [IDX_W-1:0]    nm1;
  logic [VB+1:0]       mm_t, mm_red;
  logic [VB:0]         sum_t, sum_red;
  logic                last_cell;

  logic                base_we, acc_we, scr_we;
  logic [CELL_AW-1:0]  base_waddr;
  logic [CELL_AW:0]    acc_waddr, scr_waddr;
  logic [VB-1:0]       acc_wdata, scr_wdata;
  logic [VB-1:0]       base_rd, acc_rd_a, acc_rd_b, scr_rd_a, scr_rd_b;

  // effective modulus and size
  assign m_low   = modulus_r[VB-1:0];
  assign m_eff   = (m_low < VB'(2)) ? VB'(2) : m_low;
  assign dim_eff = (dimension_r == 4'd0) ? 4'd1 :
                   ((dimension_r > MAXD4) ? MAXD4 : dimension_r);
  assign nm1     = IDX_W'(dim_eff - 4'd1);

  // one step of the bit-serial modular multiplier, r stays below m
  always_comb begin
    mm_t = {1'b0, mm_r_r, 1'b0} + (mm_b_r[VB-1] ? {2'b00, mm_a_r} : '0);
    if (mm_t >= {1'b0, m_eff, 1'b0}) begin
      mm_red = mm_t - {1'b0, m_eff, 1'b0};
    end else if (mm_t >= {2'b00, m_eff}) begin
      mm_red = mm_t - {2'b00, m_eff};
    end else begin
      mm_red = mm_t;
    end
    sum_t   = {1'b0, sum_r} + {1'b0, mm_r_r};
    sum_red = (sum_t >= {1'b0, m_eff}) ? sum_t - {1'b0, m_eff} : sum_t;
  end

  assign last_cell = (i_r == nm1) && (j_r == nm1);

  assign base_we    = (state_r == S_LWR) && ld_ok_r;
  assign base_waddr = {ld_row_r, ld_col_r};
  assign scr_we     = (state_r == S_CWR) || ((state_r == S_MACC) && sq_mode_r && (k_r == nm1));
  assign scr_waddr  = (state_r == S_CWR) ? {1'b0, i_r, j_r} : {~scr_bank_r, i_r, j_r};
  assign scr_wdata  = (state_r == S_CWR) ? mm_r_r : sum_red[VB-1:0];
  assign acc_we     = (state_r == S_INIT) ||
                      ((state_r == S_MACC) && !sq_mode_r && (k_r == nm1));
  assign acc_waddr  = (state_r == S_INIT) ? {1'b0, i_r, j_r} : {~acc_bank_r, i_r, j_r};
  assign acc_wdata  = (state_r == S_INIT) ? ((i_r == j_r) ? VB'(1) : '0) : sum_red[VB-1:0];

  mmp_ram #(.WIDTH(VB), .DEPTH(CELLS)) u_base_ram (
    .clk(clk), .we(base_we), .waddr(base_waddr), .wdata(mm_r_r),
    .raddr_a({i_r, j_r}), .rdata_a(base_rd), .raddr_b('0), .rdata_b()
  );

  mmp_ram #(.WIDTH(VB), .DEPTH(2 * CELLS)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr_a({acc_bank_r, i_r, k_r}), .rdata_a(acc_rd_a),
    .raddr_b({acc_bank_r, i_r, j_r}), .rdata_b(acc_rd_b)
  );

  mmp_ram #(.WIDTH(VB), .DEPTH(2 * CELLS)) u_scr_ram (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr_a({scr_bank_r, i_r, k_r}), .rdata_a(scr_rd_a),
    .raddr_b({scr_bank_r, k_r, j_r}), .rdata_b(scr_rd_b)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    modulus_nxt   = modulus_r;
    dimension_nxt = dimension_r;
    base_vld_nxt  = base_vld_r;
    acc_bank_nxt  = acc_bank_r;
    scr_bank_nxt  = scr_bank_r;
    sq_mode_nxt   = sq_mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    ld_ok_nxt     = ld_ok_r;
    mm_a_nxt      = mm_a_r;
    mm_b_nxt      = mm_b_r;
    mm_r_nxt      = mm_r_r;
    mm_cnt_nxt    = mm_cnt_r;
    sum_nxt       = sum_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS:   modulus_nxt = cfg_data[30:0];
        CFG_DIMENSION: dimension_nxt = cfg_data[3:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_LOAD) begin
            ld_row_nxt = IDX_W'(in_data.row_index);
            ld_col_nxt = IDX_W'(in_data.col_index);
            ld_ok_nxt  = (int'(in_data.row_index) < MAX_DIM) &&
                         (int'(in_data.col_index) < MAX_DIM);
            // reduce the entry as 1 * value mod m
            mm_a_nxt   = VB'(1);
            mm_b_nxt   = in_data.entry_value[VB-1:0];
            mm_r_nxt   = '0;
            mm_cnt_nxt = CNT_W'(VB);
            state_nxt  = S_LOAD;
          end else begin
            p_nxt        = in_data.exponent;
            acc_bank_nxt = 1'b0;
            scr_bank_nxt = 1'b0;
            i_nxt        = '0;
            j_nxt        = '0;
            k_nxt        = '0;
            state_nxt    = S_INIT;
          end
        end
      end
      S_LOAD, S_CPY, S_MMUL: begin
        mm_r_nxt   = mm_red[VB-1:0];
        mm_b_nxt   = {mm_b_r[VB-2:0], 1'b0};
        mm_cnt_nxt = mm_cnt_r - CNT_W'(1);
        if (mm_cnt_r == CNT_W'(1)) begin
          state_nxt = (state_r == S_LOAD) ? S_LWR :
                      ((state_r == S_CPY) ? S_CWR : S_MACC);
        end
      end
      S_LWR: begin
        if (ld_ok_r) begin
          base_vld_nxt[base_waddr] = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_INIT: state_nxt = S_ILD;
      S_ILD: begin
        mm_a_nxt   = VB'(1);
        mm_b_nxt   = base_vq_r ? base_rd : '0;
        mm_r_nxt   = '0;
        mm_cnt_nxt = CNT_W'(VB);
        state_nxt  = S_CPY;
      end
      S_CWR: begin
        if (last_cell) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_PSEL;
        end else begin
          if (j_r == nm1) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
          state_nxt = S_INIT;
        end
      end
      S_PSEL: begin
        i_nxt   = '0;
        j_nxt   = '0;
        k_nxt   = '0;
        sum_nxt = '0;
        if (p_r == '0) begin
          state_nxt = S_ERD;
        end else if (p_r[0]) begin
          sq_mode_nxt = 1'b0;
          state_nxt   = S_MRD;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        p_nxt   = p_r >> 1;
        i_nxt   = '0;
        j_nxt   = '0;
        k_nxt   = '0;
        sum_nxt = '0;
        if (p_r[EXP_W-1:1] != '0) begin
          sq_mode_nxt = 1'b1;
          state_nxt   = S_MRD;
        end else begin
          state_nxt = S_PSEL;
        end
      end
      S_MRD: state_nxt = S_MLD;
      S_MLD: begin
        mm_a_nxt   = sq_mode_r ? scr_rd_a : acc_rd_a;
        mm_b_nxt   = scr_rd_b;
        mm_r_nxt   = '0;
        mm_cnt_nxt = CNT_W'(VB);
        state_nxt  = S_MMUL;
      end
      S_MACC: begin
        state_nxt = S_MRD;
        if (k_r == nm1) begin
          k_nxt   = '0;
          sum_nxt = '0;
          if (last_cell) begin
            // product done: swap to the freshly written bank
            if (sq_mode_r) begin
              scr_bank_nxt = ~scr_bank_r;
              state_nxt    = S_PSEL;
            end else begin
              acc_bank_nxt = ~acc_bank_r;
              state_nxt    = S_SHIFT;
            end
          end else if (j_r == nm1) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          k_nxt   = k_r + IDX_W'(1);
          sum_nxt = sum_red[VB-1:0];
        end
      end
      S_ERD: state_nxt = S_EPUT;
      S_EPUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_row    = POS_W'(i_r);
          out_data_nxt.out_col    = POS_W'(j_r);
          out_data_nxt.out_value  = FIELD_W'(acc_rd_b);
          out_data_nxt.last_entry = last_cell;
          if (last_cell) begin
            state_nxt = S_IDLE;
          end else begin
            if (j_r == nm1) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= MODULUS_RESET;
      dimension_r <= DIMENSION_RESET;
      base_vld_r  <= '0;
      acc_bank_r  <= 1'b0;
      scr_bank_r  <= 1'b0;
      sq_mode_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      dimension_r <= dimension_nxt;
      base_vld_r  <= base_vld_nxt;
      acc_bank_r  <= acc_bank_nxt;
      scr_bank_r  <= scr_bank_nxt;
      sq_mode_r   <= sq_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_vq_r  <= base_vld_r[{i_r, j_r}];
    out_data_r <= out_data_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    ld_row_r   <= ld_row_nxt;
    ld_col_r   <= ld_col_nxt;
    ld_ok_r    <= ld_ok_nxt;
    mm_a_r     <= mm_a_nxt;
    mm_b_r     <= mm_b_nxt;
    mm_r_r     <= mm_r_nxt;
    mm_cnt_r   <= mm_cnt_nxt;
    sum_r      <= sum_nxt;
  end

endmodule

// ===== hdl/mmp_checker.sv =====
`timescale 1ns / 1ps

module mmp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mmp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mmp_pkg::out_item_t out_data
);
  import mmp_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a load item keeps the block busy while the entry is reduced
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ACT_LOAD) |=> !in_ready)
    else $error("input taken during entry reduction");

  // a power item keeps the block busy
  a_power_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ACT_POWER) |=> !in_ready)
    else $error("input taken during power computation");

  // more entries of the matrix still to come
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_entry |-> !in_ready)
    else $error("input taken before the last entry");

endmodule

bind modular_matrix_power_unit mmp_checker u_mmp_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

class matrix_power_scoreboard;
  longint unsigned base_cells[64];
  logic [30:0]     modulus_reg;
  logic [3:0]      dimension_reg;
  mmp_pkg::out_item_t pending_entries[$];
  int              errors;

  function new();
    foreach (base_cells[i]) base_cells[i] = 0;
    modulus_reg   = mmp_pkg::MODULUS_RESET;
    dimension_reg = mmp_pkg::DIMENSION_RESET;
    errors        = 0;
  endfunction

  function longint unsigned live_modulus();
    return (modulus_reg < 2) ? 64'd2 : 64'(modulus_reg);
  endfunction

  function int live_dim();
    if (dimension_reg == 0) return 1;
    if (dimension_reg > 8) return 8;
    return int'(dimension_reg);
  endfunction

  function void write_reg(logic [mmp_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    if (idx == mmp_pkg::CFG_MODULUS) modulus_reg = val;
    else dimension_reg = val[3:0];
  endfunction

  // a and b are taken by value, so aliasing the destination is harmless
  function void mat_product(ref longint unsigned dst[64], input longint unsigned a[64],
                            input longint unsigned b[64], input int n,
                            input longint unsigned m);
    longint unsigned sum;
    foreach (dst[i]) dst[i] = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        sum = 0;
        for (int k = 0; k < n; k++)
          sum = (sum + a[i*8+k] * b[k*8+j]) % m;
        dst[i*8+j] = sum;
      end
  endfunction

  function void note_item(mmp_pkg::in_item_t it);
    longint unsigned m;
    longint unsigned power_cells[64];
    longint unsigned square_cells[64];
    logic [62:0]     e;
    int              n;
    mmp_pkg::out_item_t r;
    m = live_modulus();
    n = live_dim();
    if (it.action == mmp_pkg::ACT_LOAD) begin
      base_cells[it.row_index*8 + it.col_index] = 64'(it.entry_value) % m;
      return;
    end
    foreach (power_cells[i]) power_cells[i] = 0;
    for (int i = 0; i < n; i++) power_cells[i*8+i] = 1;
    square_cells = base_cells;
    e = it.exponent;
    while (e != 0) begin
      if (e[0]) mat_product(power_cells, power_cells, square_cells, n, m);
      e = e >> 1;
      if (e != 0) mat_product(square_cells, square_cells, square_cells, n, m);
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        r.out_row    = i[2:0];
        r.out_col    = j[2:0];
        r.out_value  = power_cells[i*8+j][30:0];
        r.last_entry = (i == n-1 && j == n-1);
        pending_entries = {pending_entries, r};
      end
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_entry(mmp_pkg::out_item_t got);
    mmp_pkg::out_item_t want;
    if (pending_entries.size() == 0) begin
      report($sformatf("unexpected entry row %0d col %0d", got.out_row, got.out_col));
      return;
    end
    want = pending_entries.pop_front();
    if (got.out_row !== want.out_row)
      report($sformatf("row %0d, want %0d", got.out_row, want.out_row));
    if (got.out_col !== want.out_col)
      report($sformatf("col %0d, want %0d", got.out_col, want.out_col));
    if (got.out_value !== want.out_value)
      report($sformatf("value %0d, want %0d (row %0d col %0d)", got.out_value,
                       want.out_value, want.out_row, want.out_col));
    if (got.last_entry !== want.last_entry)
      report($sformatf("last %0b, want %0b", got.last_entry, want.last_entry));
  endtask
endclass

module tb;
  import mmp_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  matrix_power_scoreboard sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  localparam int STALL_LIMIT = 400000;

  modular_matrix_power_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_entry(out_data);
  end

  // receiver: ready runs with stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  task send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task load_entry(int r, int c, logic [30:0] v);
    in_item_t it;
    it = '0;
    it.action      = ACT_LOAD;
    it.row_index   = r[2:0];
    it.col_index   = c[2:0];
    it.entry_value = v;
    it.exponent    = 63'({$urandom, $urandom});
    send_item(it);
  endtask

  task raise_power(logic [62:0] e);
    in_item_t it;
    it.action      = ACT_POWER;
    it.row_index   = 3'($urandom);
    it.col_index   = 3'($urandom);
    it.entry_value = 31'($urandom);
    it.exponent    = e;
    send_item(it);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_entries.size() != 0) @(posedge clk);
    // a load may still be in flight with nothing to wait for
    repeat (60) @(posedge clk);
  endtask

  task set_config(logic [30:0] m, logic [3:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODULUS;
    cfg_data  <= m;
    @(posedge clk);
    cfg_index <= CFG_DIMENSION;
    cfg_data  <= {27'd0, d};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_MODULUS, m);
    sb.write_reg(CFG_DIMENSION, {27'd0, d});
  endtask

  function logic [62:0] pick_exponent(int n);
    if (n > 4) return 63'($urandom_range(0, 3));
    if (n > 2) return 63'($urandom_range(0, 1023));
    case ($urandom_range(0, 3))
      0: return 63'd0;
      1: return 63'($urandom_range(1, 50));
      2: return 63'($urandom_range(0, 65535));
      default: return 63'({$urandom, $urandom} >> 1);
    endcase
  endfunction

  function logic [30:0] pick_value();
    case ($urandom_range(0, 2))
      0: return 31'($urandom_range(0, 9));
      1: return 31'h7fffffff - 31'($urandom_range(0, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  task random_phase(int target);
    int sent;
    int n;
    n = sb.live_dim();
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) begin
        // mostly fill the live block, then raise it
        for (int k = $urandom_range(1, n*n); k > 0; k--) begin
          load_entry($urandom_range(0, n-1), $urandom_range(0, n-1), pick_value());
          sent++;
        end
        raise_power(pick_exponent(n));
        sent++;
      end else if ($urandom_range(0, 1) == 0) begin
        load_entry($urandom_range(0, 7), $urandom_range(0, 7), 31'($urandom));
        sent++;
      end else begin
        raise_power(63'($urandom_range(0, 2)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    load_entry(0, 0, 31'h7fffffff);
    load_entry(0, 1, 31'd1);
    load_entry(1, 0, 31'd0);
    load_entry(1, 1, 31'd12345);
    load_entry(7, 7, 31'd5);
    raise_power(63'd0);
    raise_power(63'd1);
    raise_power(63'h7fffffffffffffff);
    raise_power(63'h2aaaaaaaaaaaaaaa);
    // modulus below two, dimension zero and dimension above the maximum
    set_config(31'd0, 4'd0);
    raise_power(63'd3);
    set_config(31'd1, 4'd15);
    load_entry(0, 0, 31'd3);
    raise_power(63'd2);
    // largest modulus, full dimension, stale entries
    set_config(31'h7fffffff, 4'd8);
    raise_power(63'd2);
    raise_power(63'd0);

    set_config(31'($urandom), 4'd2);
    random_phase(18);

    set_config(31'($urandom_range(2, 20)), 4'($urandom_range(1, 3)));
    hold_req = 1;
    random_phase(18);

    // sender waits for every result before going on
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_entries.size() != 0) @(posedge clk);
    set_config(31'($urandom_range(1000, 100000)), 4'($urandom_range(1, 4)));
    random_phase(18);

    set_config(31'($urandom), 4'($urandom_range(9, 15)));
    random_phase(8);

    set_config(31'($urandom_range(0, 20)), 4'($urandom_range(0, 2)));
    random_phase(18);

    quiet = 1;
    set_config(31'($urandom), 4'($urandom_range(1, 3)));
    random_phase(18);

    in_valid <= 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
